// ----- rtl/mfp_pkg.sv -----
// shared constants, types and sigmoid lookup table for the perceptron datapath
// no dependencies; used by mfp_cell and mlp_forward_pass
`default_nettype none
package mfp_pkg;

  localparam int MAX_LAYERS = 4;
  localparam int MAX_WIDTH = 16;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int LAYER_W = 2;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int VAL_W = 16;
  localparam int ACT_W = 13;
  localparam int ACC_W = 38;
  localparam int SIG_IDX_W = $clog2(SIGMOID_ENTRIES);
  localparam int WADDR_W = LAYER_W + POS_W;

  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    fin;
    logic [LAYER_W-1:0]      layer;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] act;
  } tok_t;

  typedef struct packed {
    logic                    en_w;
    logic                    en_t;
    logic [LAYER_W-1:0]      layer;
    logic [POS_W-1:0]        neuron;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } wr_t;

  typedef logic [ACT_W-1:0] sig_tab_t [SIGMOID_ENTRIES];

  // restoring long division, only evaluated while building the table
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ACT_W-1:0] sig_entry(input int k);
    longint unsigned one, mag, u, term, e, den, num;
    longint sum, n, diff;
    one = 64'd1 << 30;
    n = SIGMOID_ENTRIES;
    diff = 2 * k - n;
    mag = (diff < 0) ? -diff : diff;
    u = udiv64(mag << 30, 2 * n);
    sum = one;
    term = one;
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * u) >> 30, i);
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    e = sum;
    for (int i = 0; i < 4; i++) e = (e * e + (one >> 1)) >> 30;
    den = one + e;
    num = (diff < 0) ? 4096 * e : 4096 * one;
    return ACT_W'(udiv64(num + (den >> 1), den));
  endfunction

  function automatic sig_tab_t build_sig();
    sig_tab_t t;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) t[k] = sig_entry(k);
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig();

endpackage
`default_nettype wire

// ----- rtl/mfp_cell.sv -----
// one neuron cell: weight memory, multiply-accumulate, threshold, rounding and sigmoid
// depends on mfp_pkg; tokens pass to the next cell in the following cycle
`default_nettype none
module mfp_cell
  import mfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [POS_W-1:0] cell_id,
  input  wire wr_t              wr,
  input  wire tok_t             tok_in,
  output tok_t                  tok_out,
  output logic                  done,
  output logic [ACT_W-1:0]      out
);

  logic signed [VAL_W-1:0]   wmem [2**WADDR_W];
  logic signed [VAL_W-1:0]   thr [MAX_LAYERS];
  tok_t                      s1, s2;
  logic signed [VAL_W-1:0]   wq;
  logic signed [2*VAL_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc;
  logic                      f3, f4;
  logic [LAYER_W-1:0]        lay3;
  logic signed [VAL_W-1:0]   q4;
  logic signed [ACC_W-1:0]   t_sum;
  logic signed [ACC_W-1:0]   t_rnd;
  logic signed [VAL_W-1:0]   q_next;
  logic [31:0]               idx_full;
  logic [SIG_IDX_W-1:0]      idx;

  assign tok_out = s1;

  always_comb begin
    t_sum = acc - (ACC_W'(thr[lay3]) <<< 12);
    t_rnd = (t_sum + ACC_W'(2048)) >>> 12;
    if (t_rnd > ACC_W'(32767)) q_next = 16'sh7fff;
    else if (t_rnd < -ACC_W'(32768)) q_next = 16'sh8000;
    else q_next = t_rnd[VAL_W-1:0];
  end

  always_comb begin
    idx_full = ((32'(signed'(q4)) + 32'd16384) * SIGMOID_ENTRIES) >> 15;
    if (q4 < -16'sd16384) idx = '0;
    else if (q4 >= 16'sd16384) idx = SIG_IDX_W'(SIGMOID_ENTRIES - 1);
    else idx = idx_full[SIG_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr.en_w && wr.neuron == cell_id) wmem[{wr.layer, wr.pos}] <= wr.value;
    if (wr.en_t && wr.neuron == cell_id) thr[wr.layer] <= wr.value;
    wq <= wmem[{tok_in.layer, tok_in.pos}];
    prod <= wq * s1.act;
    if (s2.valid) acc <= (s2.first ? '0 : acc) + ACC_W'(prod);
    if (s2.valid && s2.fin) lay3 <= s2.layer;
    if (f3) q4 <= q_next;
    if (f4) out <= SIG_TABLE[idx];
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      f3 <= 1'b0;
      f4 <= 1'b0;
      done <= 1'b0;
    end else begin
      s1 <= tok_in;
      s2 <= s1;
      f3 <= s2.valid && s2.fin;
      f4 <= f3;
      done <= f4;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mlp_forward_pass.sv -----
// top level: load handling, layer sequencer, activation banks and the chain of neuron cells
// depends on mfp_pkg and mfp_cell
// loads are accepted while idle; a pass runs layer by layer, issuing one token per input of
// the layer (len being the layer's input count) through the token chain of all cells and
// the cell pipeline, then registers the result and presents it
// one item at a time: no item is taken while a pass runs; result held until taken
// rst clears control state and registers to defaults; stores stay undefined until written
`default_nettype none
module mlp_forward_pass
  import mfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // layer_sel, neuron_sel, elem_sel, value, zero pad
  input  wire logic [1:0]  s_tuser,  // req_type
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // activation, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam logic [2:0] REG_LAYERS = 3'd0;
  localparam logic [2:0] REG_INPUTS = 3'd1;
  localparam logic [2:0] REG_W0 = 3'd2;
  localparam logic [2:0] REG_W1 = 3'd3;
  localparam logic [2:0] REG_W2 = 3'd4;
  localparam logic [2:0] REG_W3 = 3'd5;
  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_THRESH = 2'd1;
  localparam logic [1:0] REQ_INPUT = 2'd2;

  typedef enum logic [1:0] {IDLE, ISSUE, WAIT, OUTQ} state_t;

  state_t                  state;
  logic [2:0]              layer_count;
  logic [CNT_W-1:0]        input_count, width0, width1, width2, width3;
  logic signed [VAL_W-1:0] abuf [2*MAX_WIDTH];
  logic [LAYER_W-1:0]      layer;
  logic [2:0]              nlayers;
  logic [POS_W-1:0]        cnt;
  logic [CNT_W-1:0]        len;
  logic [ACT_W-1:0]        res;
  tok_t                    tok;
  tok_t                    chain [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0]    done;
  logic [ACT_W-1:0]        outs [MAX_WIDTH];
  wr_t                     wr;
  logic                    s_acc;
  logic [1:0]              req;
  logic [CNT_W-1:0]        cur_width;
  logic                    fin;

  function automatic logic [CNT_W-1:0] clamp_w(input logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (v > CNT_W'(MAX_WIDTH)) return CNT_W'(MAX_WIDTH);
    return v;
  endfunction

  assign s_tready = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc = s_tvalid && s_tready;
  assign req = s_tuser;

  always_comb begin
    wr.en_w = s_acc && req == REQ_WEIGHT;
    wr.en_t = s_acc && req == REQ_THRESH;
    wr.layer = s_tdata[1:0];
    wr.neuron = s_tdata[5:2];
    wr.pos = s_tdata[9:6];
    wr.value = s_tdata[25:10];
  end

  always_comb begin
    case (layer)
      2'd0: cur_width = clamp_w(width0);
      2'd1: cur_width = clamp_w(width1);
      2'd2: cur_width = clamp_w(width2);
      default: cur_width = clamp_w(width3);
    endcase
  end

  assign fin = ({1'b0, cnt} == len - CNT_W'(1));
  assign chain[0] = tok;

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
    mfp_cell u_cell (
      .clk(clk),
      .rst(rst),
      .cell_id(POS_W'(j)),
      .wr(wr),
      .tok_in(chain[j]),
      .tok_out(chain[j+1]),
      .done(done[j]),
      .out(outs[j])
    );
  end

  always_ff @(posedge clk) begin
    if (s_acc && req == REQ_INPUT) abuf[{1'b0, wr.pos}] <= wr.value;
    if (state == WAIT && done[MAX_WIDTH-1]) begin
      for (int j = 0; j < MAX_WIDTH; j++) begin
        if (CNT_W'(j) < cur_width) abuf[{~layer[0], POS_W'(j)}] <= VAL_W'(outs[j]);
      end
    end
    if (rst) begin
      state <= IDLE;
      layer_count <= 3'd2;
      input_count <= CNT_W'(9);
      width0 <= CNT_W'(9);
      width1 <= CNT_W'(1);
      width2 <= CNT_W'(1);
      width3 <= CNT_W'(1);
      tok <= '0;
      m_tvalid <= 1'b0;
      m_tdata <= '0;
      layer <= '0;
      nlayers <= 3'd1;
      cnt <= '0;
      len <= CNT_W'(1);
      res <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LAYERS: layer_count <= cfg_data[2:0];
          REG_INPUTS: input_count <= cfg_data[CNT_W-1:0];
          REG_W0: width0 <= cfg_data[CNT_W-1:0];
          REG_W1: width1 <= cfg_data[CNT_W-1:0];
          REG_W2: width2 <= cfg_data[CNT_W-1:0];
          REG_W3: width3 <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != OUTQ) m_tvalid <= 1'b0;
      tok.valid <= (state == ISSUE);
      case (state)
        IDLE: begin
          if (s_acc && req == REQ_INPUT && s_tlast) begin
            state <= ISSUE;
            layer <= '0;
            cnt <= '0;
            len <= clamp_w(input_count);
            if (layer_count == 3'd0) nlayers <= 3'd1;
            else if (layer_count > 3'(MAX_LAYERS)) nlayers <= 3'(MAX_LAYERS);
            else nlayers <= layer_count;
          end
        end
        ISSUE: begin
          tok.first <= (cnt == '0);
          tok.fin <= fin;
          tok.layer <= layer;
          tok.pos <= cnt;
          tok.act <= abuf[{layer[0], cnt}];
          cnt <= cnt + POS_W'(1);
          if (fin) state <= WAIT;
        end
        WAIT: begin
          if (done[MAX_WIDTH-1]) begin
            len <= cur_width;
            cnt <= '0;
            if ({1'b0, layer} == nlayers - 3'd1) begin
              res <= outs[0];
              state <= OUTQ;
            end else begin
              layer <= layer + LAYER_W'(1);
              state <= ISSUE;
            end
          end
        end
        OUTQ: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= 16'(res);
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/mlp_forward_pass_tb.sv -----
// self-checking testbench for mlp_forward_pass: load, input and config transactions
// with random gaps and stalls; results checked against an in-bench perceptron predictor
// depends on mfp_pkg and mlp_forward_pass
`default_nettype none
module mlp_forward_pass_tb
  import mfp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {REQ_WEIGHT = 2'd0, REQ_THRESH = 2'd1, REQ_ELEM = 2'd2,
                            REQ_NONE = 2'd3} req_e;
  typedef enum logic [2:0] {REG_LAYERS = 3'd0, REG_INPUTS = 3'd1, REG_W0 = 3'd2,
                            REG_W1 = 3'd3, REG_W2 = 3'd4, REG_W3 = 3'd5} reg_e;

  typedef struct {
    req_e        req;
    logic [1:0]  lay;
    logic [3:0]  neu;
    logic [3:0]  pos;
    logic [15:0] val;
    logic        lst;
    int          want;
  } row_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
  logic [31:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic s_tready, m_tvalid, cfg_ready;
  logic [15:0] m_tdata;

  always #10 clk = ~clk;

  mlp_forward_pass dut (.*);

  logic [12:0] sig_lut [SIGMOID_ENTRIES];
  logic signed [15:0] wgt [MAX_LAYERS*MAX_WIDTH*MAX_WIDTH];
  logic signed [15:0] thr [MAX_LAYERS*MAX_WIDTH];
  logic signed [15:0] act [2*MAX_WIDTH];
  int unsigned regs [6];
  logic [12:0] act_expected [$];
  int errors = 0;
  int quiet = 0;
  bit calm = 0;

  function automatic void fill_sigmoid();
    longint unsigned one, mag, u, term, e, den, num;
    longint acc, d;
    one = 64'd1 << 30;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      d = 2 * k - SIGMOID_ENTRIES;
      mag = d < 0 ? -d : d;
      u = (mag << 30) / (2 * SIGMOID_ENTRIES);
      acc = one;
      term = one;
      for (int i = 1; i <= 12; i++) begin
        term = ((term * u) >> 30) / i;
        acc = (i & 1) ? acc - longint'(term) : acc + longint'(term);
      end
      e = acc;
      repeat (4) e = (e * e + (one >> 1)) >> 30;
      den = one + e;
      num = d < 0 ? 4096 * e : 4096 * one;
      sig_lut[k] = 13'((num + den / 2) / den);
    end
  endfunction

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [15:0] squash(longint s);
    int idx;
    if (s < -16384) idx = 0;
    else if (s >= 16384) idx = SIGMOID_ENTRIES - 1;
    else idx = int'(((s + 16384) * SIGMOID_ENTRIES) >> 15);
    return 16'(sig_lut[idx]);
  endfunction

  function automatic logic [12:0] forward_pass();
    int unsigned layers, len, w;
    logic signed [15:0] outv [MAX_WIDTH];
    longint a, q;
    layers = clip(regs[REG_LAYERS], 4);
    len = clip(regs[REG_INPUTS], 16);
    for (int l = 0; l < layers; l++) begin
      w = clip(regs[REG_W0 + l], 16);
      for (int j = 0; j < w; j++) begin
        a = 0;
        for (int i = 0; i < len; i++)
          a += longint'(wgt[(l*MAX_WIDTH + j)*MAX_WIDTH + i]) * longint'(act[(l%2)*MAX_WIDTH + i]);
        a -= longint'(thr[l*MAX_WIDTH + j]) * 4096;
        q = (a + 2048) >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        outv[j] = squash(q);
      end
      for (int j = 0; j < w; j++) act[((l+1)%2)*MAX_WIDTH + j] = outv[j];
      len = w;
    end
    return 13'(act[(layers%2)*MAX_WIDTH]);
  endfunction

  // apply one accepted item, returns 1 with the expected activation when a pass runs
  function automatic bit mlp_infer(row_t r, output logic [12:0] res);
    res = '0;
    case (r.req)
      REQ_WEIGHT: wgt[(r.lay*MAX_WIDTH + r.neu)*MAX_WIDTH + r.pos] = r.val;
      REQ_THRESH: thr[r.lay*MAX_WIDTH + r.neu] = r.val;
      REQ_ELEM: begin
        act[r.pos] = r.val;
        if (r.lst) begin
          res = forward_pass();
          return 1;
        end
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic report(string what, logic [12:0] got, logic [12:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send(row_t r);
    logic [12:0] res;
    if (!calm && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < 31);
    end
    s_tvalid <= 1;
    s_tuser <= r.req;
    s_tlast <= r.lst;
    s_tdata <= {6'b0, r.val, r.pos, r.neu, r.lay};
    do @(posedge clk); while (!s_tready);
    if (mlp_infer(r, res))
      act_expected = {act_expected, (r.want >= 0 ? 13'(r.want) : res)};
  endtask

  task automatic write_reg(reg_e idx, logic [7:0] v);
    s_tvalid <= 0;
    @(posedge clk);
    while (act_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    regs[idx] = idx == REG_LAYERS ? v & 7 : v & 31;
  endtask

  function automatic row_t rand_row();
    row_t r;
    int p;
    p = $urandom_range(0, 99);
    r.req = p < 45 ? REQ_WEIGHT : p < 60 ? REQ_THRESH : p < 95 ? REQ_ELEM : REQ_NONE;
    r.lay = $urandom;
    r.neu = $urandom;
    r.pos = $urandom;
    r.val = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
    r.lst = r.req == REQ_ELEM ? $urandom_range(0, 99) < 12 : $urandom_range(0, 1);
    r.want = -1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 31;
      if (m_tvalid && m_tready) begin
        if (act_expected.size() == 0) report("unexpected result", m_tdata[12:0], '0);
        else begin
          if (m_tdata[12:0] !== act_expected[0])
            report("activation", m_tdata[12:0], act_expected[0]);
          void'(act_expected.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 5000) begin
      $display("FAIL mlp_forward_pass");
      $finish;
    end
  end

  row_t directed [] = '{
    '{REQ_ELEM,   2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 2048},
    '{REQ_WEIGHT, 2'd0, 4'd0,  4'd0,  16'h7fff, 1'b0, -1},
    '{REQ_WEIGHT, 2'd0, 4'd8,  4'd8,  16'h8000, 1'b1, -1},
    '{REQ_WEIGHT, 2'd3, 4'd15, 4'd15, 16'h8000, 1'b0, -1},
    '{REQ_WEIGHT, 2'd1, 4'd0,  4'd3,  16'h1000, 1'b0, -1},
    '{REQ_THRESH, 2'd1, 4'd0,  4'd0,  16'h7fff, 1'b1, -1},
    '{REQ_THRESH, 2'd3, 4'd15, 4'd0,  16'h8000, 1'b0, -1},
    '{REQ_NONE,   2'd3, 4'd15, 4'd15, 16'hffff, 1'b1, -1},
    '{REQ_ELEM,   2'd0, 4'd0,  4'd0,  16'h7fff, 1'b0, -1},
    '{REQ_ELEM,   2'd0, 4'd0,  4'd15, 16'h8000, 1'b0, -1},
    '{REQ_ELEM,   2'd3, 4'd15, 4'd8,  16'h8000, 1'b1, -1},
    '{REQ_THRESH, 2'd1, 4'd0,  4'd0,  16'h8000, 1'b0, -1},
    '{REQ_ELEM,   2'd0, 4'd0,  4'd1,  16'h1000, 1'b1, -1},
    '{REQ_THRESH, 2'd1, 4'd0,  4'd0,  16'h0000, 1'b0, -1},
    '{REQ_WEIGHT, 2'd1, 4'd0,  4'd0,  16'h2000, 1'b0, -1},
    '{REQ_ELEM,   2'd0, 4'd0,  4'd2,  16'hf000, 1'b1, -1}
  };

  logic [7:0] phase_regs [6][6] = '{
    '{8'd1, 8'd16, 8'd16, 8'd1,  8'd1,  8'd1},
    '{8'd4, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16},
    '{8'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
    '{8'd7, 8'd31, 8'd31, 8'd31, 8'd31, 8'd31},
    '{8'd3, 8'd5,  8'd3,  8'd7,  8'd2,  8'd1},
    '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}
  };

  initial begin
    row_t r;
    fill_sigmoid();
    regs = '{2, 9, 9, 1, 1, 1};
    repeat (7) @(posedge clk);
    rst <= 0;
    // clear every weight and threshold entry and the input elements so no pass reads an unwritten one
    for (int a = 0; a < MAX_LAYERS*MAX_WIDTH*MAX_WIDTH; a++)
      send('{REQ_WEIGHT, 2'(a >> 8), 4'(a >> 4), 4'(a), 16'h0, 1'b0, -1});
    for (int a = 0; a < MAX_LAYERS*MAX_WIDTH; a++)
      send('{REQ_THRESH, 2'(a >> 4), 4'(a), 4'(a), 16'h0, 1'b0, -1});
    for (int a = 0; a < MAX_WIDTH; a++)
      send('{REQ_ELEM, 2'd0, 4'd0, 4'(a), 16'h0, 1'b0, -1});
    foreach (directed[i]) send(directed[i]);
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 6; k++) write_reg(reg_e'(k), phase_regs[ph][k]);
      calm = ph == 1;
      for (int n = 0; n < 150; n++) begin
        r = rand_row();
        send(r);
      end
    end
    calm = 0;
    s_tvalid <= 0;
    while (act_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS mlp_forward_pass");
    else $display("FAIL mlp_forward_pass");
    $finish;
  end

endmodule
`default_nettype wire
